### design/safl_pkg.sv
// ----------------------------------------------------------------------------
// Sorted address floor lookup package
// Item types, compare result type and field widths shared by the block.
// ----------------------------------------------------------------------------
package safl_pkg;

    localparam int IDX_W  = 12;
    localparam int ADDR_W = 32;
    localparam int CNT_W  = 13;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef struct packed {
        logic              op;
        logic [IDX_W-1:0]  entry_index;
        logic [ADDR_W-1:0] entry_address;
        logic [ADDR_W-1:0] lookup_address;
    } t_in_item;

    typedef struct packed {
        logic              found;
        logic [IDX_W-1:0]  match_index;
        logic [ADDR_W-1:0] offset;
    } t_out_item;

    typedef struct packed {
        logic              lt;
        logic              eq;
        logic [ADDR_W-1:0] diff;
    } t_cmp;

endpackage

### design/safl_table.sv
// ----------------------------------------------------------------------------
// Address table memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module safl_table #(
    parameter int DEPTH = 4096,
    parameter int AW    = 12
) (
    input  logic                       i_clk,
    input  logic                       i_wr_en,
    input  logic [AW-1:0]              i_wr_addr,
    input  logic [safl_pkg::ADDR_W-1:0] i_wr_data,
    input  logic [AW-1:0]              i_rd_addr,
    output logic [safl_pkg::ADDR_W-1:0] o_rd_data
);

    logic [safl_pkg::ADDR_W-1:0] r_mem [DEPTH];
    logic [safl_pkg::ADDR_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

### design/safl_sub.sv
// ----------------------------------------------------------------------------
// Shared subtract and compare unit
// Computes key minus entry, with less-than and equal flags from one subtractor.
// ----------------------------------------------------------------------------
module safl_sub (
    input  logic [safl_pkg::ADDR_W-1:0] i_key,
    input  logic [safl_pkg::ADDR_W-1:0] i_entry,
    output safl_pkg::t_cmp              o_cmp
);

    logic [safl_pkg::ADDR_W:0] diff_w;

    assign diff_w     = {1'b0, i_key} - {1'b0, i_entry};
    assign o_cmp.lt   = diff_w[safl_pkg::ADDR_W];
    assign o_cmp.eq   = (diff_w[safl_pkg::ADDR_W-1:0] == '0);
    assign o_cmp.diff = diff_w[safl_pkg::ADDR_W-1:0];

endmodule

### design/sorted_address_floor_lookup.sv
// ----------------------------------------------------------------------------
// Sorted address floor lookup
// A lookup runs each probe through S_RD and S_CMP, steps back one entry through
// S_PRD and S_PCMP when needed, then waits in S_DONE until the output register is
// free; it makes at most floor(log2(count)) + 1 probes. A write leaves the block
// ready; no new item is taken until a lookup's result is in the output register.
// Reset clears the sequencer, the output valid and entry_count; the table is not.
// ----------------------------------------------------------------------------
module sorted_address_floor_lookup #(
    parameter int TABLE_DEPTH = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  safl_pkg::t_in_item               i_in_data,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output safl_pkg::t_out_item              o_out_data,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [safl_pkg::CNT_W-1:0]       i_cfg_data
);

    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = AW + 1;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_CMP  = 6'b000100,
        S_PRD  = 6'b001000,
        S_PCMP = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state                       r_state, n_state;
    logic [AW-1:0]                r_lo, n_lo;
    logic [AW-1:0]                r_hi, n_hi;
    logic [AW-1:0]                r_mid, n_mid;
    logic [safl_pkg::ADDR_W-1:0]  r_key, n_key;
    safl_pkg::t_out_item          r_res, n_res;
    safl_pkg::t_out_item          r_out, n_out;
    logic                         r_out_valid, n_out_valid;
    logic [safl_pkg::CNT_W-1:0]   r_cfg, n_cfg;

    logic                         in_acc;
    logic                         wr_en;
    logic [CW-1:0]                cnt;
    logic [AW:0]                  mid_sum;
    logic [AW-1:0]                mid_c;
    logic [AW-1:0]                rd_addr;
    logic [safl_pkg::ADDR_W-1:0]  rd_data;
    safl_pkg::t_cmp               cmp;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign in_acc = i_in_valid && o_in_ready;
    assign wr_en  = in_acc && (i_in_data.op == safl_pkg::OP_WRITE) &&
                    (32'(i_in_data.entry_index) < 32'(TABLE_DEPTH));
    assign cnt    = (32'(r_cfg) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(r_cfg);

    assign mid_sum = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid_c   = mid_sum[AW:1];

    safl_table #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_table (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(i_in_data.entry_index)),
        .i_wr_data (i_in_data.entry_address),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    safl_sub u_sub (
        .i_key   (r_key),
        .i_entry (rd_data),
        .o_cmp   (cmp)
    );

    always_comb begin
        n_state     = r_state;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_key       = r_key;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        n_cfg       = r_cfg;
        rd_addr     = mid_c;

        if (i_cfg_valid && o_cfg_ready) begin
            n_cfg = i_cfg_data;
        end
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc && (i_in_data.op == safl_pkg::OP_LOOKUP)) begin
                    n_key = i_in_data.lookup_address;
                    if (cnt == '0) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_lo    = '0;
                        n_hi    = AW'(cnt - CW'(1));
                        n_state = S_RD;
                    end
                end
            end
            S_RD: begin
                n_mid   = mid_c;
                n_state = S_CMP;
            end
            S_CMP: begin
                if (cmp.eq) begin
                    n_res   = '{found: 1'b1, match_index: safl_pkg::IDX_W'(r_mid),
                                offset: cmp.diff};
                    n_state = S_DONE;
                end else if (!cmp.lt) begin
                    if (r_mid < r_hi) begin
                        n_lo    = r_mid + AW'(1);
                        n_state = S_RD;
                    end else begin
                        n_res   = '{found: 1'b1, match_index: safl_pkg::IDX_W'(r_mid),
                                    offset: cmp.diff};
                        n_state = S_DONE;
                    end
                end else begin
                    if (r_mid > r_lo) begin
                        n_hi    = r_mid - AW'(1);
                        n_state = S_RD;
                    end else if (r_mid == '0) begin
                        n_res   = '0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_PRD;
                    end
                end
            end
            S_PRD: begin
                rd_addr = r_mid - AW'(1);
                n_mid   = r_mid - AW'(1);
                n_state = S_PCMP;
            end
            S_PCMP: begin
                n_res   = '{found: 1'b1, match_index: safl_pkg::IDX_W'(r_mid),
                            offset: cmp.diff};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_cfg       <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_cfg       <= n_cfg;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo  <= n_lo;
        r_hi  <= n_hi;
        r_mid <= n_mid;
        r_key <= n_key;
        r_res <= n_res;
        r_out <= n_out;
    end

    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CMP) |-> ((r_lo <= r_mid) && (r_mid <= r_hi)))
        else $error("Probe index left the search window.");

    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out.found) |-> ((r_out.match_index == '0) && (r_out.offset == '0)))
        else $error("Not-found item carries a nonzero index or offset.");

    a_lookup_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_in_data.op == safl_pkg::OP_LOOKUP)) |=> !o_in_ready)
        else $error("Lookup accepted but the block stayed ready.");

    a_done_delivers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_DONE) && (!r_out_valid || i_out_ready)) |=>
            (r_out_valid && (r_state == S_IDLE)))
        else $error("Finished lookup was not moved to the output register.");

endmodule
